/* hdl/checksum_frame_deframer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the checksum frame deframer
// Concurrent assertion helpers. Defining NO_ASSERTIONS leaves them empty.
// ---------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_DEFRAMER_ASSERT_SVH
`define CHECKSUM_FRAME_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at each rising clock edge outside reset.
`define CFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CFD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/cfd_pkg.sv */
// ---------------------------------------------------------------------------
// Checksum frame deframer package
// Frame phases, status codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package cfd_pkg;

   // Position within a frame.
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CTRL = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4,
      PH_TAIL = 3'd5
   } phase_type;

   // Frame status reported with each result.
   typedef enum logic [2:0] {
      ST_NONE = 3'd0,
      ST_OK   = 3'd1,
      ST_SUM  = 3'd2,
      ST_TAIL = 3'd3,
      ST_LONG = 3'd4
   } status_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_HEAD  = 3'd0,
      CSR_TAIL  = 3'd1,
      CSR_MORE  = 3'd2,
      CSR_LIMIT = 3'd3
   } csr_index_type;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CsrIdxWidth = 3;

   typedef logic [ByteWidth-1:0] byte_type;

   // Register reset values.
   localparam byte_type HeadReset  = 8'd104;
   localparam byte_type TailReset  = 8'd22;
   localparam byte_type MoreReset  = 8'd128;
   localparam byte_type LimitReset = 8'd255;

endpackage

/* hdl/checksum_frame_deframer.sv */
// ---------------------------------------------------------------------------
// Checksum frame deframer
// Hunts for framed requests in a received byte stream, passes every byte through
// and reports the frame status at the tail byte, or at an over-long length byte.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Payload                                       Handshake
// req_      in         rx_byte                                       valid/ready
// rsp_      out        data_byte, is_content, frame_end, status,     valid/ready
//                      more_follows
// csr_      in         index, data                                   valid/ready
//
// Each request gives one result. It passes through the input register and then
// the result register. The frame state updates as a request moves into the
// result register, so one request per cycle is sustained while results are
// taken. A stalled result holds the input register, which then blocks new
// requests only while it is full. Reset clears the frame state, the pipeline
// and restores the register reset values.
//
`include "checksum_frame_deframer_assert.svh"

module checksum_frame_deframer import cfd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ByteWidth-1:0]   req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ByteWidth-1:0]   rsp_data_byte,
   output logic                   rsp_is_content,
   output logic                   rsp_frame_end,
   output logic [2:0]             rsp_status,
   output logic                   rsp_more_follows,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_data
);

   // Configuration registers.
   byte_type head_ff, tail_ff, more_mask_ff, limit_ff;

   // Input register.
   logic     in_valid_ff;
   byte_type in_byte_ff;

   // Frame state.
   phase_type phase_ff, phase_in;
   byte_type  left_ff, left_in;
   byte_type  sum_ff, sum_in;
   logic      matched_ff, matched_in;
   logic      more_flag_ff, more_flag_in;

   // Result register.
   logic       out_valid_ff;
   byte_type   out_byte_ff;
   logic       out_content_ff, out_content_in;
   logic       out_end_ff, out_end_in;
   status_type out_status_ff, out_status_in;
   logic       out_more_ff, out_more_in;

   logic     advance;
   byte_type left_dec;
   byte_type sum_add;

   // The input register moves on when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= HeadReset;
         tail_ff      <= TailReset;
         more_mask_ff <= MoreReset;
         limit_ff     <= LimitReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HEAD:  head_ff      <= csr_data;
            CSR_TAIL:  tail_ff      <= csr_data;
            CSR_MORE:  more_mask_ff <= csr_data;
            CSR_LIMIT: limit_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign left_dec = left_ff - 8'd1;
   assign sum_add  = sum_ff + in_byte_ff;

   // Frame parser: next state and result for the byte in the input register.
   always_comb begin
      phase_in       = phase_ff;
      left_in        = left_ff;
      sum_in         = sum_ff;
      matched_in     = matched_ff;
      more_flag_in   = more_flag_ff;
      out_content_in = 1'b0;
      out_end_in     = 1'b0;
      out_status_in  = ST_NONE;
      out_more_in    = 1'b0;

      unique case (phase_ff)
         PH_CTRL: begin
            out_content_in = 1'b1;
            sum_in         = sum_add;
            more_flag_in   = (in_byte_ff & more_mask_ff) != 8'd0;
            phase_in       = PH_LEN;
         end
         PH_LEN: begin
            out_content_in = 1'b1;
            sum_in         = sum_add;
            if (in_byte_ff > limit_ff) begin
               out_end_in    = 1'b1;
               out_status_in = ST_LONG;
               phase_in      = PH_HUNT;
            end else begin
               left_in  = in_byte_ff;
               phase_in = (in_byte_ff == 8'd0) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            out_content_in = 1'b1;
            sum_in         = sum_add;
            left_in        = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            matched_in = (in_byte_ff == sum_ff);
            phase_in   = PH_TAIL;
         end
         PH_TAIL: begin
            out_end_in = 1'b1;
            phase_in   = PH_HUNT;
            // A bad tail outranks a bad checksum.
            priority if (in_byte_ff != tail_ff) begin
               out_status_in = ST_TAIL;
            end else if (!matched_ff) begin
               out_status_in = ST_SUM;
            end else begin
               out_status_in = ST_OK;
               out_more_in   = more_flag_ff;
            end
         end
         default: begin
            // Hunting, and any unused phase code.
            phase_in = PH_HUNT;
            if (in_byte_ff == head_ff) begin
               sum_in       = in_byte_ff;
               left_in      = 8'd0;
               matched_in   = 1'b0;
               more_flag_in = 1'b0;
               phase_in     = PH_CTRL;
            end
         end
      endcase
   end

   // Frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         left_ff      <= 8'd0;
         sum_ff       <= 8'd0;
         matched_ff   <= 1'b0;
         more_flag_ff <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         sum_ff       <= sum_in;
         matched_ff   <= matched_in;
         more_flag_ff <= more_flag_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff    <= in_byte_ff;
         out_content_ff <= out_content_in;
         out_end_ff     <= out_end_in;
         out_status_ff  <= out_status_in;
         out_more_ff    <= out_more_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_byte    = out_byte_ff;
   assign rsp_is_content   = out_content_ff;
   assign rsp_frame_end    = out_end_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_more_follows = out_more_ff;

   // A status is reported only on a frame end, and every frame end has one.
   `CFD_ASSERT_SAME(a_status_end, clock, reset, out_valid_ff,
                    ((out_status_ff != ST_NONE) == out_end_ff),
                    "status and frame end disagree")
   // The more-follows flag is only shown for a good frame.
   `CFD_ASSERT_SAME(a_more_ok, clock, reset, out_valid_ff && out_more_ff,
                    out_status_ff == ST_OK, "more_follows without a good frame")
   // A full input register behind a stalled result blocks new requests.
   `CFD_ASSERT_SAME(a_stall_block, clock, reset,
                    in_valid_ff && out_valid_ff && !rsp_ready, !req_ready,
                    "request taken while the pipeline is stalled")
   // A data byte always leaves the parser expecting more data or the checksum.
   `CFD_ASSERT_NEXT(a_data_next, clock, reset, advance && phase_ff == PH_DATA,
                    phase_ff == PH_DATA || phase_ff == PH_SUM,
                    "bad phase after a data byte")

endmodule

/* bench/checksum_frame_deframer_checker.sv */
// ---------------------------------------------------------------------------
// Checksum frame deframer checker
// Watches the request, result and register channels of the deframer. Every
// accepted request is run through a behavioral frame tracker, and the result
// it should produce is queued. Each accepted result is compared field by
// field with the oldest queued one. The mismatch count and the number of
// results still awaited are handed to the testbench top.
// ---------------------------------------------------------------------------
module checksum_frame_deframer_checker import cfd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [ByteWidth-1:0]   req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [ByteWidth-1:0]   rsp_data_byte,
   input  logic                   rsp_is_content,
   input  logic                   rsp_frame_end,
   input  logic [2:0]             rsp_status,
   input  logic                   rsp_more_follows,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_data,
   output int                     mismatch_count,
   output int                     awaiting_count
);

   // One result as the deframer should report it.
   typedef struct packed {
      byte_type   data_byte;
      logic       is_content;
      logic       frame_end;
      status_type status;
      logic       more_follows;
   } link_result_type;

   link_result_type expected_results[$];

   // Register copies.
   byte_type head_byte;
   byte_type tail_byte;
   byte_type more_bits;
   byte_type max_length;

   // Frame tracking state.
   phase_type frame_phase;
   byte_type  data_left;
   byte_type  frame_sum;
   logic      sum_ok;
   logic      more_bit;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance the frame tracker by one received byte and return its result.
   function automatic link_result_type deframe_byte(input byte_type rx);
      link_result_type r;
      r = '0;
      r.data_byte = rx;
      r.status = ST_NONE;
      unique case (frame_phase)
         PH_CTRL: begin
            r.is_content = 1'b1;
            frame_sum = frame_sum + rx;
            more_bit = |(rx & more_bits);
            frame_phase = PH_LEN;
         end
         PH_LEN: begin
            r.is_content = 1'b1;
            frame_sum = frame_sum + rx;
            if (rx > max_length) begin
               // An over-long length drops the frame right here.
               r.frame_end = 1'b1;
               r.status = ST_LONG;
               frame_phase = PH_HUNT;
            end else begin
               data_left = rx;
               frame_phase = (rx == '0) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            r.is_content = 1'b1;
            frame_sum = frame_sum + rx;
            data_left = data_left - 8'd1;
            if (data_left == '0) begin
               frame_phase = PH_SUM;
            end
         end
         PH_SUM: begin
            sum_ok = (rx == frame_sum);
            frame_phase = PH_TAIL;
         end
         PH_TAIL: begin
            // A bad tail outranks a bad checksum.
            r.frame_end = 1'b1;
            if (rx != tail_byte) begin
               r.status = ST_TAIL;
            end else if (!sum_ok) begin
               r.status = ST_SUM;
            end else begin
               r.status = ST_OK;
               r.more_follows = more_bit;
            end
            frame_phase = PH_HUNT;
         end
         default: begin
            frame_phase = PH_HUNT;
            if (rx == head_byte) begin
               frame_sum = rx;
               data_left = '0;
               sum_ok = 1'b0;
               more_bit = 1'b0;
               frame_phase = PH_CTRL;
            end
         end
      endcase
      return r;
   endfunction

   // Results are checked before this edge's request is queued, since a
   // request can never come back in the cycle it is accepted.
   always @(posedge clock) begin
      link_result_type want;
      if (reset) begin
         head_byte = HeadReset;
         tail_byte = TailReset;
         more_bits = MoreReset;
         max_length = LimitReset;
         frame_phase = PH_HUNT;
         data_left = '0;
         frame_sum = '0;
         sum_ok = 1'b0;
         more_bit = 1'b0;
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result byte %0d with no request outstanding",
                                         rsp_data_byte));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data_byte !== want.data_byte)
                  report_mismatch($sformatf("data_byte got %0d expected %0d",
                                            rsp_data_byte, want.data_byte));
               if (rsp_is_content !== want.is_content)
                  report_mismatch($sformatf("is_content on byte %0d got %0b expected %0b",
                                            want.data_byte, rsp_is_content,
                                            want.is_content));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end on byte %0d got %0b expected %0b",
                                            want.data_byte, rsp_frame_end,
                                            want.frame_end));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status on byte %0d got %0d expected %0d",
                                            want.data_byte, rsp_status, want.status));
               if (rsp_more_follows !== want.more_follows)
                  report_mismatch($sformatf("more_follows on byte %0d got %0b expected %0b",
                                            want.data_byte, rsp_more_follows,
                                            want.more_follows));
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(deframe_byte(req_rx_byte));
         end
         // Register writes apply from the next request on.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HEAD:  head_byte = csr_data;
               CSR_TAIL:  tail_byte = csr_data;
               CSR_MORE:  more_bits = csr_data;
               CSR_LIMIT: max_length = csr_data;
               default: ;
            endcase
         end
      end
      awaiting_count <= expected_results.size();
   end

endmodule

/* bench/tb_checksum_frame_deframer.sv */
// ---------------------------------------------------------------------------
// Checksum frame deframer testbench
// Drives byte streams into the deframer: a short directed set of frames
// covering every status, then random frames, noise and broken frames under
// several register settings and several patterns of sender and receiver
// idling. A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_checksum_frame_deframer import cfd_pkg::*; ();

   localparam int unsigned HalfPeriod  = 4;
   localparam int unsigned ResetCycles = 12;
   localparam int unsigned PhaseItems  = 125;
   localparam int unsigned DrainCycles = 6;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned CsrSpan     = 1 << CsrIdxWidth;
   localparam int unsigned ShortLength = 8;
   localparam byte_type    ByteMax     = 8'hFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [ByteWidth-1:0]   rsp_data_byte;
   logic                   rsp_is_content;
   logic                   rsp_frame_end;
   logic [2:0]             rsp_status;
   logic                   rsp_more_follows;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [ByteWidth-1:0]   csr_data = '0;

   int          mismatch_count;
   int          awaiting_count;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Register values as last written, used to build frames.
   byte_type cfg_head = HeadReset;
   byte_type cfg_tail = TailReset;
   byte_type cfg_limit = LimitReset;

   checksum_frame_deframer u_dut (.*);

   checksum_frame_deframer_checker u_checker (.*);

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver stalls, one decision per cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Present one request and hold it until it is accepted. Returns at the
   // falling edge after acceptance with valid still high.
   task automatic push_rx_byte(input byte_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Hold off requests until every result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaiting_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxWidth-1:0] index, input byte_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      unique case (index)
         CSR_HEAD:  cfg_head = value;
         CSR_TAIL:  cfg_tail = value;
         CSR_LIMIT: cfg_limit = value;
         default: ;
      endcase
   endtask

   // Write all registers, plus one write to an unused index that must be
   // ignored.
   task automatic write_config(input byte_type head, tail, more, limit);
      csr_write(CSR_HEAD, head);
      csr_write(CSR_TAIL, tail);
      csr_write(CSR_MORE, more);
      csr_write(CSR_LIMIT, limit);
      csr_write(CsrIdxWidth'($urandom_range(CsrSpan - 1, CSR_LIMIT + 1)),
                byte_type'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Send a frame with random data. A length above the limit stops after
   // the length byte, as the block drops the frame there.
   task automatic send_frame(input byte_type ctrl, len, input logic bad_sum,
                             input byte_type tail_byte);
      byte_type sum;
      byte_type data;
      sum = cfg_head + ctrl + len;
      push_rx_byte(cfg_head);
      push_rx_byte(ctrl);
      push_rx_byte(len);
      if (len > cfg_limit) return;
      for (int i = 0; i < len; i++) begin
         data = byte_type'($urandom);
         sum = sum + data;
         push_rx_byte(data);
      end
      push_rx_byte(bad_sum ? sum ^ byte_type'($urandom_range(255, 1)) : sum);
      push_rx_byte(tail_byte);
   endtask

   // Mostly well-formed frames with short lengths; the rest are damaged
   // frames, noise and frames broken off early.
   task automatic random_frame();
      int unsigned roll;
      int unsigned cap;
      byte_type    ctrl;
      byte_type    len;
      byte_type    wrong_tail;
      roll = $urandom_range(99);
      ctrl = byte_type'($urandom);
      cap = (cfg_limit < ShortLength) ? cfg_limit : ShortLength;
      len = ($urandom_range(39) == 0) ? byte_type'($urandom_range(cfg_limit))
                                      : byte_type'($urandom_range(cap));
      // A wrong tail that equals the head must not restart the hunt.
      wrong_tail = (cfg_head != cfg_tail && $urandom_range(1) == 1) ?
                   cfg_head : cfg_tail ^ byte_type'($urandom_range(255, 1));
      if (roll < 65) begin
         send_frame(ctrl, len, 1'b0, cfg_tail);
      end else if (roll < 73) begin
         send_frame(ctrl, len, 1'b1, cfg_tail);
      end else if (roll < 81) begin
         send_frame(ctrl, len, 1'($urandom_range(1)), wrong_tail);
      end else if (roll < 87 && cfg_limit != ByteMax) begin
         send_frame(ctrl, byte_type'($urandom_range(ByteMax, cfg_limit + 1)), 1'b0,
                    cfg_tail);
      end else if (roll < 94) begin
         repeat ($urandom_range(6, 1)) push_rx_byte(byte_type'($urandom));
      end else begin
         push_rx_byte(cfg_head);
         repeat ($urandom_range(3, 1)) push_rx_byte(byte_type'($urandom));
      end
   endtask

   // One phase of random frames; halfway through, the sender waits for the
   // block to empty before going on.
   task automatic run_phase(input int unsigned send_pct, stall_pct);
      int unsigned phase_start;
      logic        paused;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < PhaseItems) begin
         if (!paused && items_sent - phase_start >= PhaseItems / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         random_frame();
      end
      wait_drained();
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values: hunting bytes at
      // both extremes, a good zero-length frame with more-follows set, a
      // bad checksum, and a bad tail equal to the head over a bad checksum.
      push_rx_byte(8'h00);
      push_rx_byte(ByteMax);
      send_frame(MoreReset, 8'd0, 1'b0, TailReset);
      send_frame(8'h01, 8'd1, 1'b1, TailReset);
      send_frame(8'h7F, 8'd0, 1'b1, HeadReset);
      wait_drained();

      // Register extremes: a length limit of zero aborts any data length.
      write_config(8'h00, ByteMax, ByteMax, 8'h00);
      send_frame(ByteMax, 8'd1, 1'b0, ByteMax);
      send_frame(8'h00, 8'd0, 1'b0, ByteMax);
      run_phase(0, 0);

      write_config(ByteMax, 8'h00, 8'h01, ByteMax);
      run_phase(82, 0);

      write_config(byte_type'($urandom), byte_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom_range(12)));
      run_phase(0, 82);

      write_config(byte_type'($urandom), byte_type'($urandom), byte_type'($urandom),
                   ByteMax);
      run_phase(20, 20);

      write_config(byte_type'($urandom), byte_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom_range(40)));
      run_phase(82, 82);

      write_config(HeadReset, TailReset, byte_type'($urandom),
                   byte_type'($urandom_range(ByteMax)));
      run_phase(0, 0);

      wait_drained();
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
